@@ design/dlf_pkg.sv @@
// shared types and constants of the delimiter line framer
`timescale 1ns / 1ps

package dlf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WIN_BYTES = 8;
  localparam int unsigned WIN_W     = WIN_BYTES * BYTE_W;
  localparam int unsigned DLEN_W    = 4;
  localparam int unsigned MAXLEN_W  = 11;
  localparam int unsigned CNT_W     = MAXLEN_W;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned LOST_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 2'd2;

  localparam logic [WIN_W-1:0]    DELIMITER_RST = 64'd10;
  localparam logic [DLEN_W-1:0]   DELIM_LEN_RST = 4'd1;
  localparam logic [MAXLEN_W-1:0] MAX_LEN_RST   = 11'd1024;

  typedef struct packed {
    logic [WIN_W-1:0]    delimiter;
    logic [DLEN_W-1:0]   delim_len;
    logic [MAXLEN_W-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [LOST_W-1:0] lost_count;
    logic [IDX_W-1:0]  line_length;
    logic              eof_seen;
    logic              found_delimiter;
    logic              done_res;
    logic [BYTE_W-1:0] store_byte;
    logic [IDX_W-1:0]  store_index;
    logic              store_valid;
  } res_t;

endpackage

@@ design/dlf_cfg.sv @@
// configuration register file of the delimiter line framer
`timescale 1ns / 1ps

module dlf_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dlf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlf_pkg::WIN_W-1:0]     cfg_data,
  output dlf_pkg::cfg_t                 cfg
);
  import dlf_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter <= DELIMITER_RST;
      cfg_r.delim_len <= DELIM_LEN_RST;
      cfg_r.max_len   <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DELIMITER: cfg_r.delimiter <= cfg_data;
        REG_DELIM_LEN: cfg_r.delim_len <= cfg_data[DLEN_W-1:0];
        REG_MAX_LEN:   cfg_r.max_len   <= cfg_data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/dlf_match.sv @@
// parallel compare of the byte window against the delimiter
`timescale 1ns / 1ps

module dlf_match (
  input  logic [dlf_pkg::WIN_W-1:0]  window,
  input  logic [dlf_pkg::WIN_W-1:0]  delimiter,
  input  logic [dlf_pkg::DLEN_W-1:0] dlen,
  output logic                       hit
);
  import dlf_pkg::*;

  logic [WIN_BYTES-1:0] hit_by_len;
  logic [2:0]           sel;

  // length l compares delimiter byte k with window byte (8 - l + k)
  always_comb begin
    logic eq;
    hit_by_len = '0;
    for (int l = 1; l <= WIN_BYTES; l++) begin
      eq = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (window[BYTE_W*(WIN_BYTES-l+k) +: BYTE_W] != delimiter[BYTE_W*k +: BYTE_W]) begin
          eq = 1'b0;
        end
      end
      hit_by_len[l-1] = eq;
    end
  end

  assign sel = 3'(dlen - 4'd1);
  assign hit = hit_by_len[sel];

endmodule

@@ design/dlf_core.sv @@
// input stage, read state and result register of the delimiter line framer
`timescale 1ns / 1ps

module dlf_core #(
  parameter int unsigned BUF_DEPTH = 1024,
  parameter int unsigned DELIM_MAX = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dlf_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_eoi,
  input  dlf_pkg::cfg_t              cfg,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dlf_pkg::res_t              out_res
);
  import dlf_pkg::*;

  localparam logic [MAXLEN_W-1:0] BUF_LIM =
    MAXLEN_W'((BUF_DEPTH > 2047) ? 2047 : BUF_DEPTH);
  localparam logic [DLEN_W-1:0] DL_LIM = DLEN_W'(DELIM_MAX);

  logic              stg_v_r;
  logic [BYTE_W-1:0] stg_byte_r;
  logic              stg_eoi_r;

  logic [CNT_W-1:0]  stored_r, stored_nxt;
  logic [LOST_W-1:0] dropped_r, dropped_nxt;
  logic [WIN_W-1:0]  window_r, window_nxt;
  logic [DLEN_W-1:0] fill_r, fill_nxt;

  logic              out_v_r;
  res_t              res_r, res_nxt;

  logic              advance;
  logic [DLEN_W-1:0] eff_len;
  logic [MAXLEN_W-1:0] lim;
  logic [CNT_W-1:0]  cap;
  logic [WIN_W-1:0]  win_shift;
  logic [DLEN_W-1:0] fill_inc;
  logic              win_hit;
  logic              do_store;
  logic [CNT_W-1:0]  stored_upd;
  logic [LOST_W-1:0] dropped_upd;
  logic              match;

  assign advance   = stg_v_r && (!out_v_r || out_ready);
  assign in_ready  = !stg_v_r || advance;
  assign out_valid = out_v_r;
  assign out_res   = res_r;

  always_comb begin
    priority if (cfg.delim_len == '0) begin
      eff_len = 4'd1;
    end else if (cfg.delim_len > DL_LIM) begin
      eff_len = DL_LIM;
    end else begin
      eff_len = cfg.delim_len;
    end
    priority if (cfg.max_len < 11'd2) begin
      lim = 11'd2;
    end else if (cfg.max_len > BUF_LIM) begin
      lim = BUF_LIM;
    end else begin
      lim = cfg.max_len;
    end
  end

  assign cap       = lim - 11'd1;
  assign win_shift = {stg_byte_r, window_r[WIN_W-1:BYTE_W]};
  assign fill_inc  = (fill_r < DL_LIM) ? fill_r + 4'd1 : fill_r;
  assign do_store  = stored_r < cap;
  assign stored_upd  = do_store ? stored_r + 11'd1 : stored_r;
  assign dropped_upd = (!do_store && dropped_r != '1) ? dropped_r + 16'd1 : dropped_r;
  assign match     = win_hit && (fill_inc >= eff_len);

  dlf_match u_match (
    .window    (win_shift),
    .delimiter (cfg.delimiter),
    .dlen      (eff_len),
    .hit       (win_hit)
  );

  always_comb begin
    res_nxt     = '0;
    stored_nxt  = stored_r;
    dropped_nxt = dropped_r;
    window_nxt  = window_r;
    fill_nxt    = fill_r;
    if (stg_eoi_r) begin
      res_nxt.done_res    = 1'b1;
      res_nxt.eof_seen    = 1'b1;
      res_nxt.line_length = stored_r[IDX_W-1:0];
      res_nxt.lost_count  = dropped_r;
    end else begin
      res_nxt.store_valid     = do_store;
      res_nxt.store_index     = do_store ? stored_r[IDX_W-1:0] : '0;
      res_nxt.store_byte      = do_store ? stg_byte_r : '0;
      res_nxt.done_res        = match;
      res_nxt.found_delimiter = match;
      res_nxt.line_length     = stored_upd[IDX_W-1:0];
      res_nxt.lost_count      = dropped_upd;
      stored_nxt  = stored_upd;
      dropped_nxt = dropped_upd;
      window_nxt  = win_shift;
      fill_nxt    = fill_inc;
    end
    if (res_nxt.done_res) begin
      stored_nxt  = '0;
      dropped_nxt = '0;
      window_nxt  = '0;
      fill_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      stored_r  <= '0;
      dropped_r <= '0;
      window_r  <= '0;
      fill_r    <= '0;
    end else begin
      if (in_ready) begin
        stg_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r   <= 1'b1;
        stored_r  <= stored_nxt;
        dropped_r <= dropped_nxt;
        window_r  <= window_nxt;
        fill_r    <= fill_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_byte;
      stg_eoi_r  <= in_eoi;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  a_clear_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.done_res |=> stored_r == '0 && dropped_r == '0 && fill_r == '0)
    else $error("read state not cleared after a finished read");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(res_r.found_delimiter && res_r.eof_seen))
    else $error("delimiter and end of input flagged together");

  a_flag_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (res_r.found_delimiter || res_r.eof_seen) |-> res_r.done_res)
    else $error("end flag without done");

  a_store_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.store_valid |-> res_r.line_length == IDX_W'(res_r.store_index + 10'd1))
    else $error("stored byte index does not match line length");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DL_LIM)
    else $error("window fill above limit");

endmodule

@@ design/delimiter_line_framer.sv @@
// top level of the delimiter line framer
//
// Splits a byte stream into lines that end on a delimiter of 1 to 8 bytes.
// in_*: one transaction per byte; in_tuser high marks end of input instead.
// out_*: exactly one transaction per input transaction, telling where to write
//   the byte in a line buffer and, on out_tlast, that the read is finished
//   (delimiter found or end of input) with its length and lost byte count.
// cfg_*: register writes (delimiter, delimiter length, buffer size); always
//   ready; the user must see that they are written only while no transaction
//   is in flight, as the block itself does not enforce it.
// Path: a result passes through one input register and one result register.
// Throughput: one transaction per cycle while out_tready is high; the window
//   shift, the eight-way delimiter compare and the count updates sit between the two registers.
// Reset: read state and both registers clear, registers take their defaults
//   (newline delimiter, length 1, buffer size 1024).
// Stall: when out_tready is low the result holds, the input register fills,
//   and in_tready then drops until the result is taken.
`timescale 1ns / 1ps

module delimiter_line_framer #(
  parameter int unsigned BUF_DEPTH = 1024,
  parameter int unsigned DELIM_MAX = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dlf_pkg::IN_DATA_W-1:0]     in_tdata,   // data_byte
  input  logic                              in_tuser,   // end_of_input
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // store_index, store_byte, line_length, lost_count, zero pad
  output logic [dlf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [dlf_pkg::OUT_USER_W-1:0]    out_tuser,  // store_valid, found_delimiter, eof_seen
  output logic                              out_tlast,  // done_res
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dlf_pkg::WIN_W-1:0]         cfg_data
);
  import dlf_pkg::*;

  cfg_t cfg;
  res_t res;

  dlf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dlf_core #(
    .BUF_DEPTH (BUF_DEPTH),
    .DELIM_MAX (DELIM_MAX)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_eoi    (in_tuser),
    .cfg       (cfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {4'd0, res.lost_count, res.line_length, res.store_byte, res.store_index};
  assign out_tuser = {res.eof_seen, res.found_delimiter, res.store_valid};
  assign out_tlast = res.done_res;

endmodule
